// File: hdl/cscol_pkg.sv
// ----------------------------------------------------------------------------
// cscol_pkg: shared constants for the circle/segment collision test
// widths of the identity compare, the edge fraction and the pipeline latency
// ----------------------------------------------------------------------------
package cscol_pkg;

	localparam int INDEX_BITS = 16;
	localparam int IDX_PORT_BITS = 16;
	localparam int IDX_CMP_BITS = (INDEX_BITS < IDX_PORT_BITS) ? INDEX_BITS : IDX_PORT_BITS;

	// bits of the edge fraction, one divider stage per bit
	localparam int EF_BITS = 16;

	// front stages + divider stages + contact multiply + output register
	localparam int FRONT_STAGES = 7;
	localparam int LATENCY = FRONT_STAGES + EF_BITS + 2;

	// item state carried through the divider stages
	typedef struct packed {
		logic               hit;
		logic               fen;
		logic [EF_BITS-1:0] f;
		logic [65:0]        rem;
		logic [65:0]        len2;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [32:0] ex;
		logic signed [32:0] ey;
	} div_stage_t;

endpackage

// File: hdl/circle_segment_collision_test_top.sv
// ----------------------------------------------------------------------------
// circle_segment_collision_test_top: pipelined narrow-phase collision test
// ball against capsule edge or ball against ball, one candidate pair per
// cycle, exact wide-integer decisions, fraction along the edge and contact
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------
//  input     start & !busy          operation, indices, centres, radii
//  result    done (one cycle)       hit, edge_fraction, contact_x/y
//
// an item can enter on every cycle; busy is never raised
// each result passes in order through 7 front stages
// (differences, products, sums, wide partial products, compare), one
// restoring-divider stage per fraction bit, then the contact multiply and
// the output register
// reset clears the valid bits only; the receiver cannot stall, so nothing
// in the pipeline ever waits
module circle_segment_collision_test_top import cscol_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [15:0]        ball_index,
	input  logic signed [31:0] ball_x,
	input  logic signed [31:0] ball_y,
	input  logic [30:0]        ball_radius,
	input  logic [15:0]        end_a_index,
	input  logic signed [31:0] end_a_x,
	input  logic signed [31:0] end_a_y,
	input  logic [30:0]        reach,
	input  logic [15:0]        end_b_index,
	input  logic signed [31:0] end_b_x,
	input  logic signed [31:0] end_b_y,
	output logic               done,
	output logic               hit,
	output logic [16:0]        edge_fraction,
	output logic signed [31:0] contact_x,
	output logic signed [31:0] contact_y
);

	localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
	localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// stage 1: differences, summed radius, identity exclusion
	logic               v_s1, op_s1, ok_s1;
	logic signed [32:0] d1x_s1, d1y_s1, ex_s1, ey_s1, d2x_s1, d2y_s1;
	logic signed [31:0] ax_s1, ay_s1;
	logic [31:0]        r_s1;

	// stage 2: 33x33 products
	logic               v_s2, op_s2, ok_s2;
	logic signed [65:0] m_d1ex_s2, m_d1yey_s2, m_d2ex_s2, m_d2yey_s2;
	logic signed [65:0] m_d1xey_s2, m_d1yex_s2, m_exex_s2, m_eyey_s2;
	logic signed [65:0] m_d1xx_s2, m_d1yy_s2;
	logic [63:0]        r2_s2;
	logic signed [31:0] ax_s2, ay_s2;
	logic signed [32:0] ex_s2, ey_s2;

	// stage 3: dot products, cross product, squared lengths
	logic               v_s3, op_s3, ok_s3;
	logic signed [66:0] p1_s3, p2n_s3, cr_s3, len2_s3, dist2_s3;
	logic [63:0]        r2_s3;
	logic signed [31:0] ax_s3, ay_s3;
	logic signed [32:0] ex_s3, ey_s3;

	// stage 4: projection test, ball overlap, magnitude of the cross product
	logic               v_s4, op_s4, ok_s4, pass_s4, bhit_s4;
	logic [65:0]        acr_s4, p1_s4, len2_s4;
	logic [63:0]        r2_s4;
	logic signed [31:0] ax_s4, ay_s4;
	logic signed [32:0] ex_s4, ey_s4;

	// stage 5: partial products of cross^2 and r^2*len^2
	logic               v_s5, op_s5, ok_s5, pass_s5, bhit_s5;
	logic [67:0]        pp_hh_s5;
	logic [65:0]        pp_hl_s5;
	logic [63:0]        pp_ll_s5;
	logic [65:0]        q_hh_s5, q_lh_s5;
	logic [63:0]        q_hl_s5, q_ll_s5;
	logic [65:0]        p1_s5, len2_s5;
	logic signed [31:0] ax_s5, ay_s5;
	logic signed [32:0] ex_s5, ey_s5;

	// stage 6: partial products summed
	logic               v_s6, op_s6, ok_s6, pass_s6, bhit_s6;
	logic [131:0]       sq_s6, rl_s6;
	logic [65:0]        p1_s6, len2_s6;
	logic signed [31:0] ax_s6, ay_s6;
	logic signed [32:0] ex_s6, ey_s6;

	// stage 7: hit decision
	logic               v_s7, hit_s7, fen_s7;
	logic [65:0]        p1_s7, len2_s7;
	logic signed [31:0] ax_s7, ay_s7;
	logic signed [32:0] ex_s7, ey_s7;

	// divider pipeline: entry 0 is stage 7, entry k+1 has k+1 quotient bits
	logic       dv_v [0:EF_BITS];
	div_stage_t dv   [0:EF_BITS];

	// stage 8: fraction times edge vector
	logic               v_s8, hit_s8, fen_s8;
	logic [EF_BITS-1:0] f_s8;
	logic signed [50:0] mx_s8, my_s8;
	logic signed [31:0] ax_s8, ay_s8;

	// output register
	logic               done_q, hit_q;
	logic [16:0]        frac_q;
	logic signed [31:0] cx_q, cy_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= dv_v[EF_BITS];
			done_q <= v_s8;
		end
	end

	// front stages, payload only
	always_ff @(posedge clk) begin
		// stage 1
		op_s1  <= operation;
		// edge mode excludes either end ball, ball mode only the same ball
		ok_s1  <= (ball_index[IDX_CMP_BITS-1:0] != end_a_index[IDX_CMP_BITS-1:0]) &&
			(operation || (ball_index[IDX_CMP_BITS-1:0] != end_b_index[IDX_CMP_BITS-1:0]));
		d1x_s1 <= 33'(ball_x) - 33'(end_a_x);
		d1y_s1 <= 33'(ball_y) - 33'(end_a_y);
		ex_s1  <= 33'(end_b_x) - 33'(end_a_x);
		ey_s1  <= 33'(end_b_y) - 33'(end_a_y);
		d2x_s1 <= 33'(ball_x) - 33'(end_b_x);
		d2y_s1 <= 33'(ball_y) - 33'(end_b_y);
		ax_s1  <= end_a_x;
		ay_s1  <= end_a_y;
		r_s1   <= 32'(ball_radius) + 32'(reach);

		// stage 2
		op_s2      <= op_s1;
		ok_s2      <= ok_s1;
		m_d1ex_s2  <= d1x_s1 * ex_s1;
		m_d1yey_s2 <= d1y_s1 * ey_s1;
		m_d2ex_s2  <= d2x_s1 * ex_s1;
		m_d2yey_s2 <= d2y_s1 * ey_s1;
		m_d1xey_s2 <= d1x_s1 * ey_s1;
		m_d1yex_s2 <= d1y_s1 * ex_s1;
		m_exex_s2  <= ex_s1 * ex_s1;
		m_eyey_s2  <= ey_s1 * ey_s1;
		m_d1xx_s2  <= d1x_s1 * d1x_s1;
		m_d1yy_s2  <= d1y_s1 * d1y_s1;
		r2_s2      <= r_s1 * r_s1;
		ax_s2      <= ax_s1;
		ay_s2      <= ay_s1;
		ex_s2      <= ex_s1;
		ey_s2      <= ey_s1;

		// stage 3
		op_s3    <= op_s2;
		ok_s3    <= ok_s2;
		p1_s3    <= 67'(m_d1ex_s2) + 67'(m_d1yey_s2);
		// second projection is the negated value of this sum
		p2n_s3   <= 67'(m_d2ex_s2) + 67'(m_d2yey_s2);
		cr_s3    <= 67'(m_d1xey_s2) - 67'(m_d1yex_s2);
		len2_s3  <= 67'(m_exex_s2) + 67'(m_eyey_s2);
		dist2_s3 <= 67'(m_d1xx_s2) + 67'(m_d1yy_s2);
		r2_s3    <= r2_s2;
		ax_s3    <= ax_s2;
		ay_s3    <= ay_s2;
		ex_s3    <= ex_s2;
		ey_s3    <= ey_s2;

		// stage 4: strictly inside both end points
		op_s4   <= op_s3;
		ok_s4   <= ok_s3;
		pass_s4 <= !p1_s3[66] && (p1_s3 != '0) && p2n_s3[66];
		bhit_s4 <= dist2_s3 < 67'(r2_s3);
		acr_s4  <= cr_s3[66] ? 66'(-cr_s3) : 66'(cr_s3);
		p1_s4   <= 66'(p1_s3);
		len2_s4 <= 66'(len2_s3);
		r2_s4   <= r2_s3;
		ax_s4   <= ax_s3;
		ay_s4   <= ay_s3;
		ex_s4   <= ex_s3;
		ey_s4   <= ey_s3;

		// stage 5: split into 34/32 and 32/32 bit halves
		op_s5    <= op_s4;
		ok_s5    <= ok_s4;
		pass_s5  <= pass_s4;
		bhit_s5  <= bhit_s4;
		pp_hh_s5 <= acr_s4[65:32] * acr_s4[65:32];
		pp_hl_s5 <= acr_s4[65:32] * acr_s4[31:0];
		pp_ll_s5 <= acr_s4[31:0] * acr_s4[31:0];
		q_hh_s5  <= r2_s4[63:32] * len2_s4[65:32];
		q_hl_s5  <= r2_s4[63:32] * len2_s4[31:0];
		q_lh_s5  <= r2_s4[31:0] * len2_s4[65:32];
		q_ll_s5  <= r2_s4[31:0] * len2_s4[31:0];
		p1_s5    <= p1_s4;
		len2_s5  <= len2_s4;
		ax_s5    <= ax_s4;
		ay_s5    <= ay_s4;
		ex_s5    <= ex_s4;
		ey_s5    <= ey_s4;

		// stage 6: cross term of a square counts twice
		op_s6   <= op_s5;
		ok_s6   <= ok_s5;
		pass_s6 <= pass_s5;
		bhit_s6 <= bhit_s5;
		sq_s6   <= (132'(pp_hh_s5) << 64) + (132'(pp_hl_s5) << 33) + 132'(pp_ll_s5);
		rl_s6   <= (132'(q_hh_s5) << 64) + ((132'(q_hl_s5) + 132'(q_lh_s5)) << 32) +
			132'(q_ll_s5);
		p1_s6   <= p1_s5;
		len2_s6 <= len2_s5;
		ax_s6   <= ax_s5;
		ay_s6   <= ay_s5;
		ex_s6   <= ex_s5;
		ey_s6   <= ey_s5;

		// stage 7: final decision; fields only matter on an edge hit
		hit_s7  <= ok_s6 && (op_s6 ? bhit_s6 : (pass_s6 && (sq_s6 < rl_s6)));
		fen_s7  <= ok_s6 && !op_s6 && pass_s6 && (sq_s6 < rl_s6);
		p1_s7   <= p1_s6;
		len2_s7 <= len2_s6;
		ax_s7   <= ax_s6;
		ay_s7   <= ay_s6;
		ex_s7   <= ex_s6;
		ey_s7   <= ey_s6;
	end

	// divider entry; projection is below len2 on a pass
	assign dv_v[0]    = v_s7;
	assign dv[0].hit  = hit_s7;
	assign dv[0].fen  = fen_s7;
	assign dv[0].f    = '0;
	assign dv[0].rem  = p1_s7;
	assign dv[0].len2 = len2_s7;
	assign dv[0].ax   = ax_s7;
	assign dv[0].ay   = ay_s7;
	assign dv[0].ex   = ex_s7;
	assign dv[0].ey   = ey_s7;

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < EF_BITS; k++) begin : g_div
		logic [66:0] sh;
		logic        ge;
		assign sh = {dv[k].rem, 1'b0};
		assign ge = sh >= {1'b0, dv[k].len2};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			dv[k+1].hit  <= dv[k].hit;
			dv[k+1].fen  <= dv[k].fen;
			dv[k+1].f    <= {dv[k].f[EF_BITS-2:0], ge};
			dv[k+1].rem  <= ge ? 66'(sh - {1'b0, dv[k].len2}) : 66'(sh);
			dv[k+1].len2 <= dv[k].len2;
			dv[k+1].ax   <= dv[k].ax;
			dv[k+1].ay   <= dv[k].ay;
			dv[k+1].ex   <= dv[k].ex;
			dv[k+1].ey   <= dv[k].ey;
		end
	end

	// contact stage: signed product, arithmetic shift floors
	logic signed [34:0] qx, qy;
	logic signed [35:0] sx, sy;
	assign qx = 35'(mx_s8 >>> EF_BITS);
	assign qy = 35'(my_s8 >>> EF_BITS);
	assign sx = 36'(ax_s8) + 36'(qx);
	assign sy = 36'(ay_s8) + 36'(qy);

	always_ff @(posedge clk) begin
		hit_s8 <= dv[EF_BITS].hit;
		fen_s8 <= dv[EF_BITS].fen;
		f_s8   <= dv[EF_BITS].f;
		mx_s8  <= dv[EF_BITS].ex * $signed({1'b0, dv[EF_BITS].f});
		my_s8  <= dv[EF_BITS].ey * $signed({1'b0, dv[EF_BITS].f});
		ax_s8  <= dv[EF_BITS].ax;
		ay_s8  <= dv[EF_BITS].ay;

		// output register with saturation and zeroed unused fields
		hit_q  <= hit_s8;
		frac_q <= fen_s8 ? 17'(f_s8) : '0;
		if (!fen_s8) begin
			cx_q <= '0;
		end else if (sx > SAT_MAX) begin
			cx_q <= 32'(SAT_MAX);
		end else if (sx < SAT_MIN) begin
			cx_q <= 32'(SAT_MIN);
		end else begin
			cx_q <= 32'(sx);
		end
		if (!fen_s8) begin
			cy_q <= '0;
		end else if (sy > SAT_MAX) begin
			cy_q <= 32'(SAT_MAX);
		end else if (sy < SAT_MIN) begin
			cy_q <= 32'(SAT_MIN);
		end else begin
			cy_q <= 32'(sy);
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign edge_fraction = frac_q;
	assign contact_x     = cx_q;
	assign contact_y     = cy_q;

endmodule

// File: hdl/cscol_checker.sv
// ----------------------------------------------------------------------------
// cscol_checker: port-level checks of the collision test pipeline
// fixed latency, no stalls, zeroed fields on misses and in ball mode
// ----------------------------------------------------------------------------
module cscol_checker import cscol_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               operation,
	input logic [15:0]        ball_index,
	input logic signed [31:0] ball_x,
	input logic signed [31:0] ball_y,
	input logic [30:0]        ball_radius,
	input logic [15:0]        end_a_index,
	input logic signed [31:0] end_a_x,
	input logic signed [31:0] end_a_y,
	input logic [30:0]        reach,
	input logic [15:0]        end_b_index,
	input logic signed [31:0] end_b_x,
	input logic signed [31:0] end_b_y,
	input logic               done,
	input logic               hit,
	input logic [16:0]        edge_fraction,
	input logic signed [31:0] contact_x,
	input logic signed [31:0] contact_y
);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item result missing after fixed latency");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (edge_fraction == '0 && contact_x == '0 && contact_y == '0))
		else $error("fields not zero on a miss");

	a_ball_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation) |-> ##LATENCY (edge_fraction == '0 &&
		contact_x == '0 && contact_y == '0))
		else $error("fields not zero in ball mode");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !edge_fraction[16])
		else $error("edge fraction out of range");

endmodule

bind circle_segment_collision_test_top cscol_checker u_cscol_checker (.*);

// File: tb/tb_circle_segment_collision_test_top.sv
// ----------------------------------------------------------------------------
// tb_circle_segment_collision_test_top: self-checking bench for the collision test
// A short table of directed pairs runs first, then random pairs built to land
// near edges and balls. Each accepted item is scored by a wide-integer
// predictor or by the result typed into its directed row, and the expected
// results are matched in order against the done strobes.
// ----------------------------------------------------------------------------
module tb_circle_segment_collision_test_top import cscol_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {OP_EDGE = 1'b0, OP_BALL = 1'b1} op_e;

	// one candidate pair, as driven on the input ports
	typedef struct {
		op_e                op;
		logic [15:0]        bi;
		logic signed [31:0] bx, by;
		logic [30:0]        br;
		logic [15:0]        ai;
		logic signed [31:0] ax, ay;
		logic [30:0]        rch;
		logic [15:0]        ci;
		logic signed [31:0] cx, cy;
	} pair_t;

	typedef struct {
		logic               hit;
		logic [16:0]        frac;
		logic signed [31:0] px, py;
	} contact_t;

	// directed row: expected result typed in where has_exp is set
	typedef struct {
		pair_t    p;
		bit       has_exp;
		contact_t e;
	} row_t;

	// wide enough for every square product in the test
	typedef logic signed [191:0] wide_t;

	localparam int N_RANDOM = 1350;
	localparam int IDLE_LIMIT = 2000;
	localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;
	localparam logic signed [31:0] ONE = 32'sh00010000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               operation;
	logic [15:0]        ball_index;
	logic signed [31:0] ball_x;
	logic signed [31:0] ball_y;
	logic [30:0]        ball_radius;
	logic [15:0]        end_a_index;
	logic signed [31:0] end_a_x;
	logic signed [31:0] end_a_y;
	logic [30:0]        reach;
	logic [15:0]        end_b_index;
	logic signed [31:0] end_b_x;
	logic signed [31:0] end_b_y;
	logic               done;
	logic               hit;
	logic [16:0]        edge_fraction;
	logic signed [31:0] contact_x;
	logic signed [31:0] contact_y;

	circle_segment_collision_test_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .ball_index(ball_index),
		.ball_x(ball_x), .ball_y(ball_y), .ball_radius(ball_radius),
		.end_a_index(end_a_index), .end_a_x(end_a_x), .end_a_y(end_a_y),
		.reach(reach), .end_b_index(end_b_index),
		.end_b_x(end_b_x), .end_b_y(end_b_y),
		.done(done), .hit(hit), .edge_fraction(edge_fraction),
		.contact_x(contact_x), .contact_y(contact_y)
	);

	contact_t pending_contacts[$];
	int       mismatches = 0;
	int       idle_cycles = 0;
	bit       stimulus_done = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturate a 64-bit sum to the signed 32-bit range
	function automatic logic signed [31:0] sat32(longint v);
		if (v > longint'(S_MAX))
			return S_MAX;
		if (v < longint'(S_MIN))
			return S_MIN;
		return v[31:0];
	endfunction

	// exact narrow-phase decision for one pair
	function automatic contact_t collide(pair_t p);
		contact_t r;
		longint   bx, by, ax, ay, cx, cy, rad, d1x, d1y, ex, ey, d2x, d2y, q;
		wide_t    r2, p1, p2, len2, cr, quo;
		int       f;
		r = '{hit: 1'b0, frac: '0, px: '0, py: '0};
		bx = p.bx; by = p.by; ax = p.ax; ay = p.ay; cx = p.cx; cy = p.cy;
		rad = longint'(p.br) + longint'(p.rch);
		r2 = wide_t'(rad) * wide_t'(rad);
		if (p.op == OP_BALL) begin
			d1x = ax - bx;
			d1y = ay - by;
			// self pair never collides
			if (p.bi != p.ai &&
					wide_t'(d1x) * wide_t'(d1x) + wide_t'(d1y) * wide_t'(d1y) < r2)
				r.hit = 1'b1;
			return r;
		end
		// ball that is an end of the edge is skipped
		if (p.bi == p.ai || p.bi == p.ci)
			return r;
		d1x = bx - ax; d1y = by - ay;
		ex = cx - ax;  ey = cy - ay;
		d2x = bx - cx; d2y = by - cy;
		p1 = wide_t'(d1x) * wide_t'(ex) + wide_t'(d1y) * wide_t'(ey);
		p2 = -(wide_t'(d2x) * wide_t'(ex) + wide_t'(d2y) * wide_t'(ey));
		// projection must fall strictly inside; a point edge never passes
		if (p1 <= 0 || p2 <= 0)
			return r;
		len2 = wide_t'(ex) * wide_t'(ex) + wide_t'(ey) * wide_t'(ey);
		cr = wide_t'(d1x) * wide_t'(ey) - wide_t'(d1y) * wide_t'(ex);
		if (!(cr * cr < r2 * len2))
			return r;
		quo = (p1 <<< EF_BITS) / len2;
		f = int'(quo[EF_BITS-1:0]);
		r.hit = 1'b1;
		r.frac = 17'(f);
		// floor of the scaled offset, arithmetic shift rounds down
		q = (ex * longint'(f)) >>> EF_BITS;
		r.px = sat32(ax + q);
		q = (ey * longint'(f)) >>> EF_BITS;
		r.py = sat32(ay + q);
		return r;
	endfunction

	function automatic pair_t mk(op_e op, int bi, int bx, int by, int br, int ai,
			int ax, int ay, int rch, int ci, int cx, int cy);
		pair_t p;
		p.op = op; p.bi = 16'(bi); p.bx = bx; p.by = by; p.br = 31'(br);
		p.ai = 16'(ai); p.ax = ax; p.ay = ay; p.rch = 31'(rch);
		p.ci = 16'(ci); p.cx = cx; p.cy = cy;
		return p;
	endfunction

	// random value of a chosen magnitude, sign bit random
	function automatic logic signed [31:0] rnd_mag(int bits);
		logic [31:0] v;
		v = $urandom;
		if (bits < 31)
			v = $signed(v) >>> (31 - bits);
		return v;
	endfunction

	function automatic longint clamp_add(longint a, longint b);
		return longint'(sat32(a + b));
	endfunction

	// mostly geometry aimed at a hit or near miss, some pure noise
	function automatic pair_t rnd_pair();
		pair_t  p;
		int     sel, mag;
		longint t, ex, ey, ox, oy;
		sel = $urandom_range(0, 99);
		p.bi = 16'($urandom); p.ai = 16'($urandom); p.ci = 16'($urandom);
		// occasional identity clashes
		case ($urandom_range(0, 9))
			0: p.ai = p.bi;
			1: p.ci = p.bi;
			default: ;
		endcase
		if (sel < 12) begin
			p.op = op_e'($urandom_range(0, 1));
			p.bx = $urandom; p.by = $urandom; p.ax = $urandom; p.ay = $urandom;
			p.cx = $urandom; p.cy = $urandom;
			p.br = 31'($urandom); p.rch = 31'($urandom);
			return p;
		end
		mag = $urandom_range(4, 30);
		p.br = 31'($urandom) >> (31 - mag + $urandom_range(0, 2));
		p.rch = 31'($urandom) >> (31 - mag + $urandom_range(0, 3));
		p.ax = rnd_mag($urandom_range(mag, 31));
		p.ay = rnd_mag($urandom_range(mag, 31));
		if (sel < 45) begin
			p.op = OP_BALL;
			p.bx = sat32(longint'(p.ax) + longint'(rnd_mag(mag + 1)));
			p.by = sat32(longint'(p.ay) + longint'(rnd_mag(mag + 1)));
			p.cx = $urandom; p.cy = $urandom;
			return p;
		end
		p.op = OP_EDGE;
		p.cx = sat32(longint'(p.ax) + longint'(rnd_mag($urandom_range(mag, 31))));
		p.cy = sat32(longint'(p.ay) + longint'(rnd_mag($urandom_range(mag, 31))));
		if ($urandom_range(0, 29) == 0) begin
			p.cx = p.ax;
			p.cy = p.ay;
		end
		ex = longint'(p.cx) - longint'(p.ax);
		ey = longint'(p.cy) - longint'(p.ay);
		t = $urandom_range(0, 1100);
		// point along the edge, slightly past the ends at times, then offset
		ox = (ex * (t - 50)) / 1000;
		oy = (ey * (t - 50)) / 1000;
		p.bx = sat32(clamp_add(p.ax, ox) + longint'(rnd_mag(mag)));
		p.by = sat32(clamp_add(p.ay, oy) + longint'(rnd_mag(mag)));
		return p;
	endfunction

	task automatic send(pair_t p, bit has_exp, contact_t e);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		operation   <= p.op;
		ball_index  <= p.bi;
		ball_x      <= p.bx;
		ball_y      <= p.by;
		ball_radius <= p.br;
		end_a_index <= p.ai;
		end_a_x     <= p.ax;
		end_a_y     <= p.ay;
		reach       <= p.rch;
		end_b_index <= p.ci;
		end_b_x     <= p.cx;
		end_b_y     <= p.cy;
		do
			@(posedge clk);
		while (busy);
		pending_contacts.insert(pending_contacts.size(), has_exp ? e : collide(p));
	endtask

	// result side: done is sampled at the edge that ends its cycle
	always @(posedge clk) begin
		contact_t e;
		if (arst_n && done) begin
			if (pending_contacts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result hit=%0b frac=%0d x=%0d y=%0d",
						hit, edge_fraction, contact_x, contact_y);
			end else begin
				e = pending_contacts[0];
				pending_contacts.delete(0);
				if (hit !== e.hit || edge_fraction !== e.frac ||
						contact_x !== e.px || contact_y !== e.py) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp hit=%0b frac=%0d x=%0d y=%0d  ",
							"got hit=%0b frac=%0d x=%0d y=%0d"},
							e.hit, e.frac, e.px, e.py,
							hit, edge_fraction, contact_x, contact_y);
				end
			end
		end
	end

	// watchdog on cycles with no item or result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy && !stimulus_done) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_circle_segment_collision_test_top: errors");
				$finish;
			end
		end
	end

	initial begin
		row_t     rows[$];
		contact_t none;
		contact_t hit_mid;
		none = '{hit: 1'b0, frac: '0, px: '0, py: '0};
		hit_mid = '{hit: 1'b1, frac: 17'd32768, px: 5 * ONE, py: 0};

		arst_n <= 1'b0;
		start <= 1'b0;
		operation <= OP_EDGE;
		ball_index <= '0; ball_x <= '0; ball_y <= '0; ball_radius <= '0;
		end_a_index <= '0; end_a_x <= '0; end_a_y <= '0; reach <= '0;
		end_b_index <= '0; end_b_x <= '0; end_b_y <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ball across the middle of a horizontal edge
		rows.insert(rows.size(),
			'{mk(OP_EDGE, 1, 5*ONE, ONE, 2*ONE, 2, 0, 0, 0, 3, 10*ONE, 0), 1, hit_mid});
		// ball is one of the edge ends
		rows.insert(rows.size(),
			'{mk(OP_EDGE, 2, 5*ONE, ONE, 2*ONE, 2, 0, 0, 0, 3, 10*ONE, 0), 1, none});
		rows.insert(rows.size(),
			'{mk(OP_EDGE, 3, 5*ONE, ONE, 2*ONE, 2, 0, 0, 0, 3, 10*ONE, 0), 1, none});
		// point edge
		rows.insert(rows.size(),
			'{mk(OP_EDGE, 1, 0, 0, 2*ONE, 2, 0, 0, ONE, 3, 0, 0), 1, none});
		// projection on an end, and past it
		rows.insert(rows.size(),
			'{mk(OP_EDGE, 1, 0, ONE, 2*ONE, 2, 0, 0, 0, 3, 10*ONE, 0), 1, none});
		rows.insert(rows.size(),
			'{mk(OP_EDGE, 1, 11*ONE, 0, 2*ONE, 2, 0, 0, 0, 3, 10*ONE, 0), 1, none});
		// exactly touching, no hit
		rows.insert(rows.size(),
			'{mk(OP_EDGE, 1, 5*ONE, 2*ONE, 2*ONE, 2, 0, 0, 0, 3, 10*ONE, 0), 1, none});
		// ball pairs: overlap, self, touching, zero radii
		rows.insert(rows.size(), '{mk(OP_BALL, 1, 0, 0, ONE, 2, ONE, 0, ONE, 0, 0, 0),
			1, '{hit: 1'b1, frac: '0, px: '0, py: '0}});
		rows.insert(rows.size(),
			'{mk(OP_BALL, 7, 0, 0, ONE, 7, ONE, 0, ONE, 0, 0, 0), 1, none});
		rows.insert(rows.size(),
			'{mk(OP_BALL, 1, 0, 0, ONE, 2, 2*ONE, 0, ONE, 0, 0, 0), 1, none});
		rows.insert(rows.size(),
			'{mk(OP_BALL, 1, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0), 1, none});
		// extremes of every field
		rows.insert(rows.size(), '{mk(OP_BALL, 16'hffff, S_MIN, S_MIN, 31'h7fffffff, 0,
			S_MAX, S_MAX, 31'h7fffffff, 16'hffff, S_MAX, S_MIN), 0, none});
		rows.insert(rows.size(), '{mk(OP_BALL, 0, S_MAX, S_MIN, 31'h7fffffff, 16'hffff,
			S_MIN, S_MAX, 0, 0, 0, 0), 0, none});
		rows.insert(rows.size(), '{mk(OP_EDGE, 16'h8000, 0, 0, 31'h7fffffff, 16'hffff,
			S_MIN, S_MIN, 31'h7fffffff, 0, S_MAX, S_MAX), 0, none});
		rows.insert(rows.size(), '{mk(OP_EDGE, 16'h0001, 0, 0, 31'h7fffffff, 16'hfffe,
			S_MAX, S_MIN, 31'h7fffffff, 16'h7fff, S_MIN, S_MAX), 0, none});
		rows.insert(rows.size(), '{mk(OP_EDGE, 5, -3*ONE, 7*ONE, ONE, 6, S_MIN, 0, ONE,
			9, S_MAX, 0), 0, none});
		rows.insert(rows.size(), '{mk(OP_EDGE, 5, 123, -456, 1000, 6, -ONE, -ONE, 0,
			9, ONE, ONE), 0, none});
		rows.insert(rows.size(), '{mk(OP_EDGE, 5, ONE, 0, 0, 6, 0, S_MIN, 31'h7fffffff,
			9, 0, S_MAX), 0, none});

		foreach (rows[i])
			send(rows[i].p, rows[i].has_exp, rows[i].e);
		repeat (N_RANDOM)
			send(rnd_pair(), 0, none);
		start <= 1'b0;
		stimulus_done = 1;

		while (pending_contacts.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (mismatches == 0 && pending_contacts.size() == 0)
			$display("tb_circle_segment_collision_test_top: clean");
		else
			$display("tb_circle_segment_collision_test_top: errors");
		$finish;
	end

endmodule

// File: circle_segment_collision_test_top.f
hdl/cscol_pkg.sv
hdl/circle_segment_collision_test_top.sv
hdl/cscol_checker.sv
tb/tb_circle_segment_collision_test_top.sv
